>>> sv/rrcr_pkg.sv
// shared constants, codes and the token type of the request/reply correlation router
`timescale 1ns / 1ps

package rrcr_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int ID_W          = 32;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  // incoming message kinds
  localparam logic [2:0] REQ_PING    = 3'd0;
  localparam logic [2:0] REQ_EVENT   = 3'd1;
  localparam logic [2:0] REQ_SERVICE = 3'd2;
  localparam logic [2:0] REQ_REPLY   = 3'd3;
  localparam logic [2:0] REQ_ERROR   = 3'd4;

  // outgoing actions
  localparam logic [2:0] ACT_ACK        = 3'd0;
  localparam logic [2:0] ACT_FORWARD    = 3'd1;
  localparam logic [2:0] ACT_REPLY      = 3'd2;
  localparam logic [2:0] ACT_ERR_OWNER  = 3'd3;
  localparam logic [2:0] ACT_ERR_SOURCE = 3'd4;

  // error codes
  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_INVALID     = 3'd1;
  localparam logic [2:0] ERR_ROUTE       = 3'd2;
  localparam logic [2:0] ERR_FULL        = 3'd3;
  localparam logic [2:0] ERR_DELIVERY    = 3'd4;
  localparam logic [2:0] ERR_UNSUPPORTED = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_WALK,
    ST_FINISH
  } state_t;

  // token that walks the slot chain, one cell per cycle
  typedef struct packed {
    logic            active;
    logic            store;
    logic            take;
    logic            found;
    logic [ID_W-1:0] tag;
    logic [ID_W-1:0] owner;
    logic [ID_W-1:0] hit_owner;
  } tok_t;

endpackage

>>> sv/rrcr_cell.sv
// one tracking slot: claims on a pending store, frees on a pending matching take
`timescale 1ns / 1ps

module rrcr_cell (
  input  logic             clk,
  input  logic             rst,
  input  rrcr_pkg::tok_t   tok_in,
  output rrcr_pkg::tok_t   tok_out
);

  logic                      used;
  logic [rrcr_pkg::ID_W-1:0] tag;
  logic [rrcr_pkg::ID_W-1:0] owner;
  logic                      claim;
  logic                      hit;
  rrcr_pkg::tok_t            tok_next;

  always_comb begin
    claim    = tok_in.active && tok_in.store && !used;
    hit      = tok_in.active && tok_in.take && used && (tag == tok_in.tag);
    tok_next = tok_in;
    if (claim) begin
      // a take riding with the store lands on this fresh slot: both cancel
      tok_next.store = 1'b0;
      tok_next.take  = 1'b0;
    end
    if (hit) begin
      tok_next.take      = 1'b0;
      tok_next.found     = 1'b1;
      tok_next.hit_owner = owner;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used           <= 1'b0;
      tok_out.active <= 1'b0;
    end else begin
      tok_out <= tok_next;
      if (claim && !tok_in.take) begin
        used <= 1'b1;
      end else if (hit) begin
        used <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (claim && !tok_in.take) begin
      tag   <= tok_in.tag;
      owner <= tok_in.owner;
    end
  end

endmodule

>>> sv/request_reply_correlation_router.sv
// top level of the request/reply correlation router with its slot chain
`timescale 1ns / 1ps

// Routes one classified broker message per transaction. Invalid packets,
// pings, events, unknown opcodes and requests rejected up front go from the
// input latch through the EVAL and FINISH states into the output register,
// after which the next message can be accepted. A service request that is
// forwarded or fails delivery, and a service reply or error, walks a token
// down a chain of TABLE_ENTRIES slot cells, one cell per cycle: its result
// reaches the output register through FINISH once the token has left the
// last cell. A reply with no matching slot produces no output transaction
// and returns to IDLE when its token leaves the chain. One message is in the
// block at a time; a finished result sits in the output register while the
// next message is accepted, and out_stall on a waiting result holds the next
// result back in FINISH. The slot table comes out of reset empty with no
// clearing pass.
module request_reply_correlation_router (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic        packet_ok,
  input  logic [31:0] msg_corr,
  input  logic [31:0] source_id,
  input  logic [31:0] service_id,
  input  logic        delivery_ok,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  action,
  output logic [31:0] dest_id,
  output logic [31:0] corr_out,
  output logic [2:0]  error_code,
  output logic [31:0] handled_total,
  output logic [31:0] requests_forwarded,
  output logic [31:0] replies_forwarded
);

  localparam int N = rrcr_pkg::TABLE_ENTRIES;

  rrcr_pkg::state_t state, state_next;

  // latched input transaction
  logic [2:0]  r_type;
  logic        r_ok;
  logic [31:0] r_corr;
  logic [31:0] r_src;
  logic [31:0] r_route;
  logic        r_deliver;

  // pending result
  logic [2:0]  res_action;
  logic [31:0] res_dest;
  logic [31:0] res_corr;
  logic [2:0]  res_err;

  // counters
  logic [31:0]                handled_count;
  logic [31:0]                request_count;
  logic [31:0]                reply_count;
  logic [rrcr_pkg::CNT_W-1:0] used_count;

  // token chain, entry 0 is the launch register
  rrcr_pkg::tok_t launch;
  rrcr_pkg::tok_t chain [N+1];
  rrcr_pkg::tok_t tok_last;

  // decode of the latched transaction
  logic        ev_launch;
  logic        ev_store;
  logic        ev_take;
  logic        ev_forward;
  logic [2:0]  ev_action;
  logic [31:0] ev_dest;
  logic [31:0] ev_corr;
  logic [2:0]  ev_err;
  logic        is_take_kind;
  logic        walk_done;
  logic        out_free;

  assign chain[0] = launch;
  assign tok_last = chain[N];

  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cell
      rrcr_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .tok_in  (chain[gi]),
        .tok_out (chain[gi+1])
      );
    end
  endgenerate

  assign is_take_kind = (r_type == rrcr_pkg::REQ_REPLY) || (r_type == rrcr_pkg::REQ_ERROR);
  assign walk_done    = tok_last.active;
  assign out_free     = !out_valid || !out_stall;

  // decode: what the message does, before any table walk
  always_comb begin
    ev_launch  = 1'b0;
    ev_store   = 1'b0;
    ev_take    = 1'b0;
    ev_forward = 1'b0;
    ev_action  = rrcr_pkg::ACT_ERR_SOURCE;
    ev_dest    = r_src;
    ev_corr    = r_corr;
    ev_err     = rrcr_pkg::ERR_NONE;
    if (!r_ok) begin
      ev_corr = '0;
      ev_err  = rrcr_pkg::ERR_INVALID;
    end else begin
      unique case (r_type)
        rrcr_pkg::REQ_PING, rrcr_pkg::REQ_EVENT: begin
          ev_action = rrcr_pkg::ACT_ACK;
        end
        rrcr_pkg::REQ_SERVICE: begin
          if (r_route == '0) begin
            ev_err = rrcr_pkg::ERR_ROUTE;
          end else if ((r_corr == '0) || (r_src == '0) ||
                       (used_count == rrcr_pkg::CNT_W'(N))) begin
            // zero ids count as no room
            ev_err = rrcr_pkg::ERR_FULL;
          end else begin
            ev_launch = 1'b1;
            ev_store  = 1'b1;
            // failed delivery frees the lowest slot with this tag again
            ev_take   = !r_deliver;
            if (r_deliver) begin
              ev_forward = 1'b1;
              ev_action  = rrcr_pkg::ACT_FORWARD;
              ev_dest    = r_route;
            end else begin
              ev_err = rrcr_pkg::ERR_DELIVERY;
            end
          end
        end
        rrcr_pkg::REQ_REPLY, rrcr_pkg::REQ_ERROR: begin
          ev_launch = 1'b1;
          ev_take   = 1'b1;
        end
        default: begin
          ev_err = rrcr_pkg::ERR_UNSUPPORTED;
        end
      endcase
    end
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    unique case (state)
      rrcr_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = rrcr_pkg::ST_EVAL;
        end
      end
      rrcr_pkg::ST_EVAL: begin
        state_next = ev_launch ? rrcr_pkg::ST_WALK : rrcr_pkg::ST_FINISH;
      end
      rrcr_pkg::ST_WALK: begin
        if (walk_done) begin
          // an unmatched reply ends here without a result
          if (is_take_kind && !tok_last.found) begin
            state_next = rrcr_pkg::ST_IDLE;
          end else begin
            state_next = rrcr_pkg::ST_FINISH;
          end
        end
      end
      rrcr_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = rrcr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rrcr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrcr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // input latch
  always_ff @(posedge clk) begin
    if ((state == rrcr_pkg::ST_IDLE) && in_valid) begin
      r_type    <= req_type;
      r_ok      <= packet_ok;
      r_corr    <= msg_corr;
      r_src     <= source_id;
      r_route   <= service_id;
      r_deliver <= delivery_ok;
    end
  end

  // counters and token launch
  always_ff @(posedge clk) begin
    if (rst) begin
      handled_count <= '0;
      request_count <= '0;
      reply_count   <= '0;
      used_count    <= '0;
      launch.active <= 1'b0;
    end else begin
      launch.active <= 1'b0;
      if (state == rrcr_pkg::ST_EVAL) begin
        if (r_ok) begin
          handled_count <= handled_count + 32'd1;
        end
        if (ev_forward) begin
          request_count <= request_count + 32'd1;
          used_count    <= used_count + rrcr_pkg::CNT_W'(1);
        end
        if (ev_launch) begin
          launch.active <= 1'b1;
        end
        launch.store     <= ev_store;
        launch.take      <= ev_take;
        launch.found     <= 1'b0;
        launch.tag       <= r_corr;
        launch.owner     <= r_src;
        launch.hit_owner <= '0;
      end
      if ((state == rrcr_pkg::ST_WALK) && walk_done && is_take_kind && tok_last.found) begin
        reply_count <= reply_count + 32'd1;
        used_count  <= used_count - rrcr_pkg::CNT_W'(1);
      end
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (state == rrcr_pkg::ST_EVAL) begin
      res_action <= ev_action;
      res_dest   <= ev_dest;
      res_corr   <= ev_corr;
      res_err    <= ev_err;
    end
    if ((state == rrcr_pkg::ST_WALK) && walk_done && is_take_kind) begin
      res_action <= (r_type == rrcr_pkg::REQ_ERROR) ? rrcr_pkg::ACT_ERR_OWNER
                                                    : rrcr_pkg::ACT_REPLY;
      res_dest   <= tok_last.hit_owner;
      res_err    <= rrcr_pkg::ERR_NONE;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= (state == rrcr_pkg::ST_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if ((state == rrcr_pkg::ST_FINISH) && out_free) begin
      action             <= res_action;
      dest_id            <= res_dest;
      corr_out           <= res_corr;
      error_code         <= res_err;
      handled_total      <= handled_count;
      requests_forwarded <= request_count;
      replies_forwarded  <= reply_count;
    end
  end

`ifndef SYNTHESIS
  a_used_bounded: assert property (@(posedge clk) disable iff (rst)
    used_count <= rrcr_pkg::CNT_W'(N))
    else $error("slot count above table size");

  a_launch_follows_eval: assert property (@(posedge clk) disable iff (rst)
    (state == rrcr_pkg::ST_EVAL) && ev_launch |=> launch.active && (state == rrcr_pkg::ST_WALK))
    else $error("table walk not launched");

  a_token_in_walk: assert property (@(posedge clk) disable iff (rst)
    tok_last.active |-> (state == rrcr_pkg::ST_WALK))
    else $error("token left chain outside walk");

  a_store_placed: assert property (@(posedge clk) disable iff (rst)
    tok_last.active |-> !tok_last.store)
    else $error("store found no free slot");
`endif

endmodule
